@@ rtl/core/spfc_pkg.sv @@
// shared types and constants of the servo packet framer and checker
package spfc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int JOB_BYTES       = 6;

    // request selectors
    localparam logic [2:0] REQ_READ      = 3'd0;
    localparam logic [2:0] REQ_WR_START  = 3'd1;
    localparam logic [2:0] REQ_WR_BYTE   = 3'd2;
    localparam logic [2:0] REQ_POS_START = 3'd3;
    localparam logic [2:0] REQ_POS_ENTRY = 3'd4;
    localparam logic [2:0] REQ_REPLY     = 3'd5;

    // verdict codes
    localparam logic [2:0] VD_OK     = 3'd0;
    localparam logic [2:0] VD_LEN    = 3'd1;
    localparam logic [2:0] VD_ECHO   = 3'd2;
    localparam logic [2:0] VD_SUM    = 3'd3;
    localparam logic [2:0] VD_MOTOR  = 3'd4;
    localparam logic [2:0] VD_UNEXP  = 3'd5;

    // frame constants
    localparam logic [7:0] CMD_READ        = 8'h03;
    localparam logic [7:0] CMD_WRITE       = 8'h04;
    localparam logic [7:0] CMD_POS         = 8'h06;
    localparam logic [7:0] OPT_READ        = 8'h83;
    localparam logic [7:0] OPT_WRITE       = 8'h80;
    localparam logic [7:0] OPT_POS         = 8'h00;
    localparam logic [7:0] ECHO_BIT        = 8'h80;
    localparam logic [7:0] READ_FRAME_LEN  = 8'h07;
    localparam logic [7:0] WRITE_HDR_BASE  = 8'h07;
    localparam logic [7:0] POS_HDR_BASE    = 8'h06;
    localparam logic [7:0] WRITE_COUNT_ONE = 8'h01;
    localparam logic [7:0] READ_REPLY_ADD  = 8'd5;
    localparam logic [7:0] WRITE_REPLY_LEN = 8'd5;
    localparam logic [7:0] POS_REPLY_LEN   = 8'd7;

    // frame progress, one-hot
    typedef enum logic [3:0] {
        PF_IDLE  = 4'b0001,
        PF_WRITE = 4'b0010,
        PF_POS   = 4'b0100,
        PF_REPLY = 4'b1000
    } t_pend;

    // work handed from the front to the back
    typedef struct packed {
        logic                           is_verdict;
        logic [2:0]                     n_bytes;
        logic                           add_sum;
        logic                           clr_sum;
        logic [JOB_BYTES-1:0][7:0]      bytes;
        logic [2:0]                     verdict;
        logic [7:0]                     status;
    } t_job;

endpackage

@@ rtl/core/spfc_ifs.sv @@
// request and result channel interfaces
interface spfc_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [7:0]         motor_id;
    logic [7:0]         reg_addr;
    logic [7:0]         item_count;
    logic [7:0]         data_byte;
    logic signed [15:0] position;
    logic [15:0]        move_time;

    modport source(output valid, req_type, motor_id, reg_addr, item_count, data_byte,
                   position, move_time, input ready);
    modport sink(input valid, req_type, motor_id, reg_addr, item_count, data_byte,
                 position, move_time, output ready);
endinterface

interface spfc_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [2:0] verdict;
    logic [7:0] motor_status;

    modport source(output valid, out_kind, tx_byte, frame_end, verdict, motor_status,
                   input ready);
    modport sink(input valid, out_kind, tx_byte, frame_end, verdict, motor_status,
                 output ready);
endinterface

@@ rtl/core/servo_packet_framer_checker.sv @@
// top level of the servo packet framer and reply checker
// usage:
//  - i_req carries requests: read, write start, write payload byte, position start,
//    position entry and reply byte; a transaction completes when valid and ready are high
//  - o_res carries results one per transaction: command frame bytes (out_kind 0) with
//    frame_end on the checksum byte, or a reply verdict (out_kind 1)
//  - a request is decoded in the cycle it is taken and may leave a job in a short queue;
//    the expander drains it into an output register, one result per cycle when not stalled
//  - the first result of a request passes through the job queue and then the output register
//  - a read request expands into 7 results, a write start 4 or 7, a payload byte 1 or 4,
//    a position start 3 or 6, a position entry 3 or 6, a verdict 1; that expander is what
//    sets the sustained rate
//  - i_req.ready drops only while the job queue is full, so requests keep flowing while
//    a result waits in the output register
//  - when o_res.ready is low the output register holds its transaction and the
//    expander stops; requests are still taken until the queue fills
//  - reset (i_rst_n low, synchronous) empties the queue, drops the output transaction,
//    clears the checksum and returns the framer to idle with no reply awaited
module servo_packet_framer_checker #(
    parameter int QUEUE_DEPTH = spfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spfc_req_if.sink  i_req,
    spfc_res_if.source o_res
);
    import spfc_pkg::*;

    logic w_full;
    logic w_push;
    logic w_pop;
    logic w_head_valid;
    t_job w_job;
    t_job w_head;

    spfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    spfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    spfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_res        (o_res)
    );

endmodule

@@ rtl/core/spfc_front.sv @@
// front end: accepts requests, tracks frame and reply state, issues jobs
module spfc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spfc_req_if.sink      i_req,
    input  logic          i_full,
    output logic          o_push,
    output spfc_pkg::t_job o_job
);
    import spfc_pkg::*;

    t_pend      r_pend, n_pend;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_opt, n_opt;
    logic [7:0] r_exp, n_exp;
    logic [7:0] r_items, n_items;
    logic [7:0] r_addr, n_addr;
    logic [15:0] r_time, n_time;
    logic [7:0] r_rx_cnt, n_rx_cnt;
    logic [7:0] r_rx_sum, n_rx_sum;
    logic [7:0] r_rx_len, n_rx_len;
    logic [7:0] r_rx_cmd, n_rx_cmd;
    logic [7:0] r_rx_st, n_rx_st;

    logic       w_acc;
    logic       w_can_start;
    logic [7:0] w_cnt;
    logic [7:0] w_db;
    logic [7:0] w_items_dec;
    logic [7:0] w_read_exp;
    logic [7:0] w_pos_exp;
    logic [7:0] w_len_b, w_cmd_b, w_st_b;
    logic       w_rx_done;
    logic [2:0] w_vd;
    logic [7:0] w_vst;

    assign i_req.ready = !i_full;
    assign w_acc       = i_req.valid && !i_full;
    assign w_can_start = (r_pend == PF_IDLE) || (r_pend == PF_REPLY);
    assign w_cnt       = i_req.item_count;
    assign w_db        = i_req.data_byte;
    assign w_items_dec = r_items - 8'd1;
    assign w_read_exp  = w_cnt + READ_REPLY_ADD;
    assign w_pos_exp   = (w_cnt == 8'd1) ? POS_REPLY_LEN : 8'd0;

    // reply bytes land in their slot before the check looks at them
    assign w_len_b   = (r_rx_cnt == 8'd0) ? w_db : r_rx_len;
    assign w_cmd_b   = (r_rx_cnt == 8'd1) ? w_db : r_rx_cmd;
    assign w_st_b    = (r_rx_cnt == 8'd2) ? w_db : r_rx_st;
    assign w_rx_done = ({1'b0, r_rx_cnt} + 9'd1) >= {1'b0, r_exp};

    always_comb begin
        w_vd  = VD_OK;
        w_vst = 8'd0;
        if (w_len_b != r_exp) begin
            w_vd = VD_LEN;
        end else if (w_cmd_b != (r_cmd | ECHO_BIT)) begin
            w_vd = VD_ECHO;
        end else if (r_rx_sum != w_db) begin
            w_vd = VD_SUM;
        end else if (r_opt == 8'd0 && w_st_b != 8'd0) begin
            w_vd  = VD_MOTOR;
            w_vst = w_st_b;
        end
    end

    always_comb begin
        n_pend   = r_pend;
        n_cmd    = r_cmd;
        n_opt    = r_opt;
        n_exp    = r_exp;
        n_items  = r_items;
        n_addr   = r_addr;
        n_time   = r_time;
        n_rx_cnt = r_rx_cnt;
        n_rx_sum = r_rx_sum;
        n_rx_len = r_rx_len;
        n_rx_cmd = r_rx_cmd;
        n_rx_st  = r_rx_st;
        o_push   = 1'b0;
        o_job    = '0;
        if (w_acc) begin
            unique case (i_req.req_type)
                REQ_READ, REQ_WR_START, REQ_POS_START: begin
                    if (w_can_start) begin
                        o_push        = 1'b1;
                        o_job.clr_sum = 1'b1;
                        n_rx_cnt      = 8'd0;
                        n_rx_sum      = 8'd0;
                        n_rx_len      = 8'd0;
                        n_rx_cmd      = 8'd0;
                        n_rx_st       = 8'd0;
                        if (i_req.req_type == REQ_READ) begin
                            n_cmd         = CMD_READ;
                            n_opt         = OPT_READ;
                            n_exp         = w_read_exp;
                            o_job.bytes   = {w_cnt, i_req.reg_addr, i_req.motor_id,
                                             OPT_READ, CMD_READ, READ_FRAME_LEN};
                            o_job.n_bytes = 3'd6;
                            o_job.add_sum = 1'b1;
                            n_pend        = (w_read_exp != 8'd0) ? PF_REPLY : PF_IDLE;
                        end else if (i_req.req_type == REQ_WR_START) begin
                            n_cmd         = CMD_WRITE;
                            n_opt         = OPT_WRITE;
                            n_exp         = WRITE_REPLY_LEN;
                            n_addr        = i_req.reg_addr;
                            n_items       = w_cnt;
                            o_job.bytes   = {WRITE_COUNT_ONE, i_req.reg_addr, i_req.motor_id,
                                             OPT_WRITE, CMD_WRITE, WRITE_HDR_BASE + w_cnt};
                            if (w_cnt == 8'd0) begin
                                o_job.n_bytes = 3'd6;
                                o_job.add_sum = 1'b1;
                                n_pend        = PF_REPLY;
                            end else begin
                                o_job.n_bytes = 3'd4;
                                n_pend        = PF_WRITE;
                            end
                        end else begin
                            n_cmd         = CMD_POS;
                            n_opt         = OPT_POS;
                            n_exp         = w_pos_exp;
                            n_time        = i_req.move_time;
                            n_items       = w_cnt;
                            o_job.bytes   = {8'd0, i_req.move_time[15:8], i_req.move_time[7:0],
                                             OPT_POS, CMD_POS,
                                             POS_HDR_BASE + {w_cnt[6:0], 1'b0} + w_cnt};
                            if (w_cnt == 8'd0) begin
                                o_job.n_bytes = 3'd5;
                                o_job.add_sum = 1'b1;
                                n_pend        = PF_IDLE;
                            end else begin
                                o_job.n_bytes = 3'd3;
                                n_pend        = PF_POS;
                            end
                        end
                    end
                end
                REQ_WR_BYTE: begin
                    if (r_pend == PF_WRITE) begin
                        o_push      = 1'b1;
                        n_items     = w_items_dec;
                        o_job.bytes = {16'd0, 8'd0, WRITE_COUNT_ONE, r_addr, w_db};
                        if (w_items_dec == 8'd0) begin
                            o_job.n_bytes = 3'd3;
                            o_job.add_sum = 1'b1;
                            n_pend        = (r_exp != 8'd0) ? PF_REPLY : PF_IDLE;
                        end else begin
                            o_job.n_bytes = 3'd1;
                        end
                    end
                end
                REQ_POS_ENTRY: begin
                    if (r_pend == PF_POS) begin
                        o_push      = 1'b1;
                        n_items     = w_items_dec;
                        o_job.bytes = {8'd0, r_time[15:8], r_time[7:0],
                                       i_req.position[15:8], i_req.position[7:0],
                                       i_req.motor_id};
                        if (w_items_dec == 8'd0) begin
                            o_job.n_bytes = 3'd5;
                            o_job.add_sum = 1'b1;
                            n_pend        = (r_exp != 8'd0) ? PF_REPLY : PF_IDLE;
                        end else begin
                            o_job.n_bytes = 3'd3;
                        end
                    end
                end
                REQ_REPLY: begin
                    o_push           = 1'b1;
                    o_job.is_verdict = 1'b1;
                    if (r_pend != PF_REPLY) begin
                        o_job.verdict = VD_UNEXP;
                    end else begin
                        n_rx_len = w_len_b;
                        n_rx_cmd = w_cmd_b;
                        n_rx_st  = w_st_b;
                        n_rx_cnt = r_rx_cnt + 8'd1;
                        if (w_rx_done) begin
                            o_job.verdict = w_vd;
                            o_job.status  = w_vst;
                            n_pend        = PF_IDLE;
                        end else begin
                            o_push   = 1'b0;
                            n_rx_sum = r_rx_sum + w_db;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= PF_IDLE;
            r_cmd    <= 8'd0;
            r_opt    <= 8'd0;
            r_exp    <= 8'd0;
            r_items  <= 8'd0;
            r_addr   <= 8'd0;
            r_time   <= 16'd0;
            r_rx_cnt <= 8'd0;
            r_rx_sum <= 8'd0;
            r_rx_len <= 8'd0;
            r_rx_cmd <= 8'd0;
            r_rx_st  <= 8'd0;
        end else begin
            r_pend   <= n_pend;
            r_cmd    <= n_cmd;
            r_opt    <= n_opt;
            r_exp    <= n_exp;
            r_items  <= n_items;
            r_addr   <= n_addr;
            r_time   <= n_time;
            r_rx_cnt <= n_rx_cnt;
            r_rx_sum <= n_rx_sum;
            r_rx_len <= n_rx_len;
            r_rx_cmd <= n_rx_cmd;
            r_rx_st  <= n_rx_st;
        end
    end

    // a reply is only awaited with a nonzero length
    a_reply_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == PF_REPLY |-> r_exp != 8'd0)
        else $error("awaiting reply with zero length");

    // an open frame always has entries left
    a_items_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == PF_WRITE || r_pend == PF_POS) |-> r_items != 8'd0)
        else $error("open frame with no entries left");

endmodule

@@ rtl/core/spfc_queue.sv @@
// short job queue between front and back
module spfc_queue #(
    parameter int DEPTH = spfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spfc_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_head_valid,
    output spfc_pkg::t_job o_head,
    input  logic           i_pop
);
    import spfc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue fill out of range");

endmodule

@@ rtl/core/spfc_back.sv @@
// back end: expands jobs into result transactions, keeps the frame checksum
module spfc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  spfc_pkg::t_job i_head,
    output logic           o_pop,
    spfc_res_if.source     o_res
);
    import spfc_pkg::*;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic [2:0] verdict;
        logic [7:0] motor_status;
    } t_res;

    logic       r_valid;
    t_res       r_out, n_out;
    logic [2:0] r_idx, n_idx;
    logic [7:0] r_sum, n_sum;
    logic       w_can_load;
    logic       w_step;
    logic       w_is_sum;
    logic       w_last;
    logic [7:0] w_cur;

    always_comb begin
        case (r_idx)
            3'd0:    w_cur = i_head.bytes[0];
            3'd1:    w_cur = i_head.bytes[1];
            3'd2:    w_cur = i_head.bytes[2];
            3'd3:    w_cur = i_head.bytes[3];
            3'd4:    w_cur = i_head.bytes[4];
            3'd5:    w_cur = i_head.bytes[5];
            default: w_cur = 8'd0;
        endcase
    end

    assign w_can_load = !r_valid || o_res.ready;
    assign w_step     = i_head_valid && w_can_load;
    assign w_is_sum   = i_head.add_sum && (r_idx == i_head.n_bytes);
    assign w_last     = i_head.is_verdict || w_is_sum ||
                        (!i_head.add_sum && (r_idx == i_head.n_bytes - 3'd1));
    assign o_pop      = w_step && w_last;

    always_comb begin
        n_out = r_out;
        n_idx = r_idx;
        n_sum = r_sum;
        if (w_step) begin
            n_idx = w_last ? 3'd0 : r_idx + 3'd1;
            if (i_head.is_verdict) begin
                n_out = '{out_kind: 1'b1, tx_byte: 8'd0, frame_end: 1'b1,
                          verdict: i_head.verdict, motor_status: i_head.status};
            end else if (w_is_sum) begin
                n_out = '{out_kind: 1'b0, tx_byte: r_sum, frame_end: 1'b1,
                          verdict: VD_OK, motor_status: 8'd0};
            end else begin
                n_out = '{out_kind: 1'b0, tx_byte: w_cur, frame_end: 1'b0,
                          verdict: VD_OK, motor_status: 8'd0};
                // first byte of a new frame restarts the checksum
                n_sum = (i_head.clr_sum && r_idx == 3'd0) ? w_cur : r_sum + w_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
            r_sum   <= 8'd0;
        end else begin
            r_idx <= n_idx;
            r_sum <= n_sum;
            if (w_step) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid        = r_valid;
    assign o_res.out_kind     = r_out.out_kind;
    assign o_res.tx_byte      = r_out.tx_byte;
    assign o_res.frame_end    = r_out.frame_end;
    assign o_res.verdict      = r_out.verdict;
    assign o_res.motor_status = r_out.motor_status;

    // a job part-way through expansion never leaves the queue head
    a_idx_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 3'd0 |-> i_head_valid && !i_head.is_verdict)
        else $error("expansion index set without a byte job");

endmodule

@@ sim/servo_packet_framer_checker_tb.sv @@
// testbench for the servo packet framer and reply checker: directed and random frames
module servo_packet_framer_checker_tb;
    import spfc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 6;
    localparam int RAND_ITEMS  = 120;

    // ways of spoiling a reply
    localparam int FAULT_NONE  = 0;
    localparam int FAULT_LEN   = 1;
    localparam int FAULT_ECHO  = 2;
    localparam int FAULT_SUM   = 3;
    localparam int FAULT_MOTOR = 4;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [7:0]  addr;
        logic [7:0]  count;
        logic [7:0]  data;
        logic [15:0] pos;
        logic [15:0] mtime;
    } t_servo_req;

    typedef struct {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic [2:0] vd;
        logic [7:0] status;
    } t_servo_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spfc_req_if req_bus();
    spfc_res_if res_bus();

    servo_packet_framer_checker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // framer model state
    logic [7:0]  last_cmd   = '0;
    logic [7:0]  last_opt   = '0;
    logic [7:0]  reply_len  = '0;
    logic [7:0]  tx_csum    = '0;
    logic [7:0]  left       = '0;
    logic [7:0]  hold_addr  = '0;
    logic [15:0] hold_time  = '0;
    logic [7:0]  rx_cnt     = '0;
    logic [7:0]  rx_csum    = '0;
    logic [7:0]  rx_len     = '0;
    logic [7:0]  rx_echo    = '0;
    logic [7:0]  rx_status  = '0;
    t_pend       frame_state = PF_IDLE;

    t_servo_out framer_out_q[$];

    int mismatches   = 0;
    int cycles       = 0;
    int random_items = 0;
    bit idle_on      = 1'b0;
    bit counting     = 1'b0;

    function automatic void emit_byte(input logic [7:0] b, input logic last);
        t_servo_out o;
        o.kind = 1'b0;
        o.tx = b;
        o.last = last;
        o.vd = VD_OK;
        o.status = 8'h00;
        framer_out_q.push_back(o);
        tx_csum = tx_csum + b;
    endfunction

    function automatic void emit_verdict(input logic [2:0] v, input logic [7:0] st);
        t_servo_out o;
        o.kind = 1'b1;
        o.tx = 8'h00;
        o.last = 1'b1;
        o.vd = v;
        o.status = st;
        framer_out_q.push_back(o);
    endfunction

    function automatic void open_cmd(input logic [7:0] code, input logic [7:0] opt,
                                     input logic [7:0] rlen);
        last_cmd = code;
        last_opt = opt;
        reply_len = rlen;
        tx_csum = '0;
        rx_cnt = '0;
        rx_csum = '0;
        rx_len = '0;
        rx_echo = '0;
        rx_status = '0;
    endfunction

    function automatic void close_frame();
        emit_byte(tx_csum, 1'b1);
        frame_state = (reply_len != 8'd0) ? PF_REPLY : PF_IDLE;
    endfunction

    function automatic void write_close();
        emit_byte(hold_addr, 1'b0);
        emit_byte(WRITE_COUNT_ONE, 1'b0);
        close_frame();
    endfunction

    function automatic void pos_close();
        emit_byte(hold_time[7:0], 1'b0);
        emit_byte(hold_time[15:8], 1'b0);
        close_frame();
    endfunction

    // works out the bytes and verdicts one request causes; returns 0 if it is ignored
    function automatic bit frame_and_check(input t_servo_req r);
        bit can_start;
        bit took;
        logic [2:0] v;
        logic [7:0] st;
        can_start = (frame_state == PF_IDLE) || (frame_state == PF_REPLY);
        took = 1'b0;
        case (r.kind)
            REQ_READ: if (can_start) begin
                took = 1'b1;
                open_cmd(CMD_READ, OPT_READ, r.count + READ_REPLY_ADD);
                emit_byte(READ_FRAME_LEN, 1'b0);
                emit_byte(CMD_READ, 1'b0);
                emit_byte(OPT_READ, 1'b0);
                emit_byte(r.id, 1'b0);
                emit_byte(r.addr, 1'b0);
                emit_byte(r.count, 1'b0);
                close_frame();
            end
            REQ_WR_START: if (can_start) begin
                took = 1'b1;
                open_cmd(CMD_WRITE, OPT_WRITE, WRITE_REPLY_LEN);
                hold_addr = r.addr;
                left = r.count;
                emit_byte(WRITE_HDR_BASE + r.count, 1'b0);
                emit_byte(CMD_WRITE, 1'b0);
                emit_byte(OPT_WRITE, 1'b0);
                emit_byte(r.id, 1'b0);
                if (r.count == 8'd0) write_close();
                else frame_state = PF_WRITE;
            end
            REQ_WR_BYTE: if (frame_state == PF_WRITE) begin
                took = 1'b1;
                emit_byte(r.data, 1'b0);
                left = left - 8'd1;
                if (left == 8'd0) write_close();
            end
            REQ_POS_START: if (can_start) begin
                took = 1'b1;
                open_cmd(CMD_POS, OPT_POS, (r.count == 8'd1) ? POS_REPLY_LEN : 8'd0);
                hold_time = r.mtime;
                left = r.count;
                emit_byte(POS_HDR_BASE + 8'd3 * r.count, 1'b0);
                emit_byte(CMD_POS, 1'b0);
                emit_byte(OPT_POS, 1'b0);
                if (r.count == 8'd0) pos_close();
                else frame_state = PF_POS;
            end
            REQ_POS_ENTRY: if (frame_state == PF_POS) begin
                took = 1'b1;
                emit_byte(r.id, 1'b0);
                emit_byte(r.pos[7:0], 1'b0);
                emit_byte(r.pos[15:8], 1'b0);
                left = left - 8'd1;
                if (left == 8'd0) pos_close();
            end
            REQ_REPLY: begin
                took = 1'b1;
                if (frame_state != PF_REPLY) begin
                    emit_verdict(VD_UNEXP, 8'h00);
                end else begin
                    if (rx_cnt == 8'd0) rx_len = r.data;
                    else if (rx_cnt == 8'd1) rx_echo = r.data;
                    else if (rx_cnt == 8'd2) rx_status = r.data;
                    if ({1'b0, rx_cnt} + 9'd1 >= {1'b0, reply_len}) begin
                        v = VD_OK;
                        st = 8'h00;
                        if (rx_len != reply_len) v = VD_LEN;
                        else if (rx_echo != (last_cmd | ECHO_BIT)) v = VD_ECHO;
                        else if (rx_csum != r.data) v = VD_SUM;
                        else if (last_opt == 8'h00 && rx_status != 8'h00) begin
                            v = VD_MOTOR;
                            st = rx_status;
                        end
                        emit_verdict(v, st);
                        frame_state = PF_IDLE;
                    end else begin
                        rx_csum = rx_csum + r.data;
                    end
                    rx_cnt = rx_cnt + 8'd1;
                end
            end
            default: ;
        endcase
        return took;
    endfunction

    function automatic t_servo_req rand_req(input logic [2:0] kind);
        t_servo_req r;
        r.kind = kind;
        r.id = 8'($urandom_range(255));
        r.addr = 8'($urandom_range(255));
        r.count = 8'($urandom_range(250));
        r.data = 8'($urandom_range(255));
        r.pos = 16'($urandom_range(65535));
        r.mtime = 16'($urandom_range(65535));
        return r;
    endfunction

    task automatic send_req(input t_servo_req r);
        bit took;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.req_type = r.kind;
        req_bus.motor_id = r.id;
        req_bus.reg_addr = r.addr;
        req_bus.item_count = r.count;
        req_bus.data_byte = r.data;
        req_bus.position = r.pos;
        req_bus.move_time = r.mtime;
        req_bus.valid = 1'b1;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        took = frame_and_check(r);
        if (took && counting) random_items++;
        @(negedge i_clk);
    endtask

    // builds a reply to the pending command from the model state and sends n_send bytes of it
    task automatic send_reply(input int fault, input int n_send);
        logic [7:0] rb[$];
        logic [7:0] csum;
        logic [7:0] rlen;
        t_servo_req r;
        int i;
        rlen = reply_len;
        rb.push_back(fault == FAULT_LEN ? rlen ^ 8'($urandom_range(1, 255)) : rlen);
        rb.push_back(fault == FAULT_ECHO ? (last_cmd | ECHO_BIT) ^ 8'($urandom_range(1, 255))
                                         : (last_cmd | ECHO_BIT));
        rb.push_back(fault == FAULT_MOTOR ? 8'($urandom_range(1, 255)) : 8'h00);
        for (i = 3; i < int'(rlen) - 1; i++) rb.push_back(8'($urandom_range(255)));
        csum = '0;
        foreach (rb[k]) csum = csum + rb[k];
        rb.push_back(fault == FAULT_SUM ? csum + 8'($urandom_range(1, 255)) : csum);
        for (i = 0; i < n_send && i < rb.size(); i++) begin
            r = rand_req(REQ_REPLY);
            r.data = rb[i];
            send_req(r);
        end
    endtask

    task automatic test_read_frame();
        t_servo_req r;
        r = rand_req(REQ_READ);
        r.id = 8'h00;
        r.addr = 8'hFF;
        r.count = 8'd0;
        send_req(r);
        // longest read, its reply is dropped by the next start
        r = rand_req(REQ_READ);
        r.id = 8'hFF;
        r.addr = 8'h00;
        r.count = 8'd250;
        send_req(r);
    endtask

    task automatic test_write_frame();
        t_servo_req r;
        r = rand_req(REQ_WR_START);
        r.count = 8'd0;
        send_req(r);
        r = rand_req(REQ_WR_START);
        r.count = 8'd2;
        send_req(r);
        r = rand_req(REQ_WR_BYTE);
        r.data = 8'h00;
        send_req(r);
        r.data = 8'hFF;
        send_req(r);
    endtask

    task automatic test_position_frame();
        t_servo_req r;
        // zero entries: no reply is awaited, so a reply byte is unexpected
        r = rand_req(REQ_POS_START);
        r.count = 8'd0;
        r.mtime = 16'hFFFF;
        send_req(r);
        send_req(rand_req(REQ_REPLY));
        r = rand_req(REQ_POS_START);
        r.count = 8'd1;
        r.mtime = 16'h0000;
        send_req(r);
        r = rand_req(REQ_POS_ENTRY);
        r.pos = 16'h8000;
        send_req(r);
        send_reply(FAULT_MOTOR, int'(POS_REPLY_LEN));
    endtask

    task automatic test_out_of_order();
        t_servo_req r;
        send_req(rand_req(REQ_WR_BYTE));
        send_req(rand_req(REQ_POS_ENTRY));
        send_req(rand_req(3'd6));
        send_req(rand_req(3'd7));
        r = rand_req(REQ_WR_START);
        r.count = 8'd1;
        send_req(r);
        send_req(rand_req(REQ_READ));
        send_req(rand_req(REQ_POS_ENTRY));
        send_req(rand_req(REQ_WR_BYTE));
    endtask

    // anything but the request that the open frame wants
    function automatic logic [2:0] stray_kind(input logic [2:0] wanted);
        logic [2:0] k;
        do k = 3'($urandom_range(7)); while (k == wanted);
        return k;
    endfunction

    task automatic test_random_traffic();
        t_servo_req r;
        int pick;
        int n;
        int fault;
        counting = 1'b1;
        idle_on = 1'b0;
        while (random_items < RAND_ITEMS) begin
            if (random_items >= 40) idle_on = 1'b1;
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_req(rand_req(stray_kind(REQ_READ)));
            end else if (pick < 40) begin
                r = rand_req(REQ_READ);
                r.count = ($urandom_range(19) == 0) ? 8'($urandom_range(250))
                                                    : 8'($urandom_range(6));
                send_req(r);
            end else if (pick < 70) begin
                r = rand_req(REQ_WR_START);
                r.count = 8'($urandom_range(5));
                n = int'(r.count);
                send_req(r);
                repeat (n) begin
                    if ($urandom_range(19) == 0) send_req(rand_req(stray_kind(REQ_WR_BYTE)));
                    send_req(rand_req(REQ_WR_BYTE));
                end
            end else begin
                r = rand_req(REQ_POS_START);
                r.count = 8'($urandom_range(3));
                n = int'(r.count);
                send_req(r);
                repeat (n) begin
                    if ($urandom_range(19) == 0) send_req(rand_req(stray_kind(REQ_POS_ENTRY)));
                    send_req(rand_req(REQ_POS_ENTRY));
                end
            end
            if (frame_state == PF_REPLY) begin
                fault = $urandom_range(6);
                if (fault > FAULT_MOTOR) fault = FAULT_NONE;
                // now and then a reply cut short, dropped by the next start
                if ($urandom_range(9) == 0)
                    send_reply(fault, int'($urandom_range(1, int'(reply_len) - 1)));
                else
                    send_reply(fault, int'(reply_len));
            end
        end
        counting = 1'b0;
    endtask

    always @(negedge i_clk) begin
        res_bus.ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_servo_out want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (framer_out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with none expected: kind %0d byte %02h end %0d vd %0d st %02h",
                             res_bus.out_kind, res_bus.tx_byte, res_bus.frame_end,
                             res_bus.verdict, res_bus.motor_status);
            end else begin
                want = framer_out_q.pop_front();
                if (res_bus.out_kind !== want.kind || res_bus.tx_byte !== want.tx ||
                    res_bus.frame_end !== want.last || res_bus.verdict !== want.vd ||
                    res_bus.motor_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d byte %02h end %0d vd %0d st %02h",
                                 want.kind, want.tx, want.last, want.vd, want.status);
                        $display("          got      kind %0d byte %02h end %0d vd %0d st %02h",
                                 res_bus.out_kind, res_bus.tx_byte, res_bus.frame_end,
                                 res_bus.verdict, res_bus.motor_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_READ;
        req_bus.motor_id = '0;
        req_bus.reg_addr = '0;
        req_bus.item_count = '0;
        req_bus.data_byte = '0;
        req_bus.position = '0;
        req_bus.move_time = '0;
        res_bus.ready = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;
        test_read_frame();
        test_write_frame();
        test_position_frame();
        test_out_of_order();
        test_random_traffic();
        req_bus.valid = 1'b0;
        while (framer_out_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
